// ===== hw/rtl/agc_pkg.sv =====
`default_nettype none

package agc_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int MAG_W             = 15;
	localparam int HANG_W            = 16;
	localparam int SHIFT_W           = 5;
	localparam int ENV_FRAC_BITS_DEF = 16;

	// quotient of the setpoint by a 15-bit magnitude fits 14 bits
	localparam int QUOT_W = 14;
	localparam int ACC_W  = 31;

	localparam logic [QUOT_W-1:0]   SETPOINT = 14'd16383;
	localparam logic [SAMPLE_W-1:0] LIMIT    = 16'd32767;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ATTACK_SHIFT = 2'd0;
	localparam cfg_idx_t CFG_DECAY_SHIFT  = 2'd1;
	localparam cfg_idx_t CFG_HANG_TICKS   = 2'd2;

	localparam logic [SHIFT_W-1:0] ATTACK_SHIFT_RST = 5'd2;
	localparam logic [SHIFT_W-1:0] DECAY_SHIFT_RST  = 5'd13;
	localparam logic [HANG_W-1:0]  HANG_TICKS_RST   = 16'd25000;

	typedef struct packed {
		logic [SHIFT_W-1:0] attack_shift;
		logic [SHIFT_W-1:0] decay_shift;
		logic [HANG_W-1:0]  hang_ticks;
	} agc_cfg_t;

	typedef enum logic [1:0] {
		MODE_ATTACK,
		MODE_HANG,
		MODE_DECAY
	} env_mode_t;

	typedef struct packed {
		logic calc;
		logic upd;
	} env_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_UPD,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} agc_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/audio_agc_hang_softclip.sv =====
// Audio AGC with attack, hang and decay, then soft compression and clamp.
// Input channel pcm_in / pcm_in_valid / pcm_in_ready carries one signed
// 16-bit sample per beat; output channel audio_out / audio_out_valid /
// audio_out_ready returns exactly one processed sample per input beat, in order.
// Config: cfg_we writes cfg_data into register cfg_index (0 attack_shift,
// 1 decay_shift, 2 hang_ticks) on the same edge; other indexes are ignored.
// Write config only while the block is idle.
// Processing runs envelope calc and update, divider load, the serial
// divide/multiply that retires one quotient bit (14 bits) per cycle, and
// the output step. With a zero envelope integer part the divider is skipped.
// One sample is in flight at a time.
// A finished result sits in the output register, so the next input beat is
// taken while it waits; a stalled receiver holds the block after that sample.
// Reset: envelope and hang counter clear, registers take 2, 13 and 25000,
// output goes invalid.
`default_nettype none

module audio_agc_hang_softclip #(
	parameter int ENVELOPE_FRACTION_BITS = agc_pkg::ENV_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pcm_in_valid,
	output logic                                  pcm_in_ready,
	input  logic signed [agc_pkg::SAMPLE_W-1:0]   pcm_in,
	output logic                                  audio_out_valid,
	input  logic                                  audio_out_ready,
	output logic signed [agc_pkg::SAMPLE_W-1:0]   audio_out,
	input  logic                                  cfg_we,
	input  logic        [agc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [agc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import agc_pkg::*;

	agc_cfg_t                   cfg_q;
	agc_state_t                 state_q;
	agc_state_t                 state_d;
	logic signed [SAMPLE_W-1:0] pcm_q;
	logic signed [SAMPLE_W-1:0] audio_out_q;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       out_load;
	env_ctl_t                   env_ctl;
	div_ctl_t                   div_ctl;
	logic        [MAG_W-1:0]    mag;
	logic signed [ACC_W-1:0]    product;
	logic                       div_done;

	logic                       neg;
	logic        [ACC_W-1:0]    abs_val;
	logic        [ACC_W-1:0]    soft_val;
	logic        [ACC_W-1:0]    clamp_val;
	logic        [SAMPLE_W-1:0] clip_mag;
	logic signed [SAMPLE_W-1:0] clip_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_shift <= ATTACK_SHIFT_RST;
			cfg_q.decay_shift  <= DECAY_SHIFT_RST;
			cfg_q.hang_ticks   <= HANG_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTACK_SHIFT: cfg_q.attack_shift <= cfg_data[SHIFT_W-1:0];
				CFG_DECAY_SHIFT:  cfg_q.decay_shift  <= cfg_data[SHIFT_W-1:0];
				CFG_HANG_TICKS:   cfg_q.hang_ticks   <= cfg_data[HANG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || audio_out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (pcm_in_valid) state_d = ST_CALC;
			ST_CALC: state_d = ST_UPD;
			ST_UPD:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pcm_in_ready = (state_q == ST_IDLE);
		env_ctl.calc = (state_q == ST_CALC);
		env_ctl.upd  = (state_q == ST_UPD);
		div_ctl.load = (state_q == ST_LOAD);
		div_ctl.step = (state_q == ST_DIV) && !div_done;
		out_load     = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (audio_out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pcm_in_valid && pcm_in_ready) begin
			pcm_q <= pcm_in;
		end
		if (out_load) begin
			audio_out_q <= clip_out;
		end
	end

	agc_env #(
		.ENV_FRAC_BITS(ENVELOPE_FRACTION_BITS)
	) u_env (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (env_ctl),
		.cfg   (cfg_q),
		.sample(pcm_q),
		.mag   (mag)
	);

	agc_divmul u_divmul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.mag    (mag),
		.sample (pcm_q),
		.product(product),
		.done   (div_done)
	);

	// symmetric soft knee at the setpoint, then clamp, on the magnitude
	always_comb begin
		neg     = product[ACC_W-1];
		abs_val = neg ? ACC_W'(-product) : ACC_W'(product);
		if (abs_val > ACC_W'(SETPOINT)) begin
			soft_val = ACC_W'(SETPOINT) + ((abs_val - ACC_W'(SETPOINT)) >> 1);
		end else begin
			soft_val = abs_val;
		end
		clamp_val = (soft_val > ACC_W'(LIMIT)) ? ACC_W'(LIMIT) : soft_val;
		clip_mag  = clamp_val[SAMPLE_W-1:0];
		clip_out  = neg ? -$signed(clip_mag) : $signed(clip_mag);
	end

	assign audio_out_valid = out_valid_q;
	assign audio_out       = audio_out_q;

	a_out_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		audio_out_valid |-> audio_out != $signed({1'b1, {(SAMPLE_W-1){1'b0}}}))
		else $error("output reached negative full scale");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_in_valid && pcm_in_ready |=> state_q == ST_CALC)
		else $error("accepted beat did not start processing");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> audio_out_valid && state_q == ST_IDLE)
		else $error("result load did not raise output valid");

endmodule

`default_nettype wire

// ===== hw/rtl/agc_env.sv =====
`default_nettype none

module agc_env #(
	parameter int ENV_FRAC_BITS = agc_pkg::ENV_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  agc_pkg::env_ctl_t                   ctl,
	input  agc_pkg::agc_cfg_t                   cfg,
	input  logic signed [agc_pkg::SAMPLE_W-1:0] sample,
	output logic        [agc_pkg::MAG_W-1:0]    mag
);
	import agc_pkg::*;

	localparam int EnvW = MAG_W + ENV_FRAC_BITS;
	localparam logic [EnvW-1:0] EnvMax = {{MAG_W{1'b1}}, {ENV_FRAC_BITS{1'b0}}};

	logic [EnvW-1:0]   env_q;
	logic [EnvW-1:0]   scaled;
	logic [EnvW-1:0]   delta_s1;
	logic [HANG_W-1:0] hold_q;
	env_mode_t         mode_s1;
	logic              attack;

	assign scaled = {sample[MAG_W-1:0], {ENV_FRAC_BITS{1'b0}}};
	assign attack = !sample[SAMPLE_W-1] && (sample != '0) && (scaled > env_q);
	assign mag    = env_q[EnvW-1:ENV_FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= MODE_HANG;
		end else if (ctl.calc) begin
			if (attack) begin
				mode_s1 <= MODE_ATTACK;
			end else if (hold_q != '0) begin
				mode_s1 <= MODE_HANG;
			end else begin
				mode_s1 <= MODE_DECAY;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			if (attack) begin
				delta_s1 <= (scaled - env_q) >> cfg.attack_shift;
			end else begin
				delta_s1 <= env_q >> cfg.decay_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			hold_q <= '0;
		end else if (ctl.upd) begin
			unique case (mode_s1)
				MODE_ATTACK: begin
					env_q  <= env_q + delta_s1;
					hold_q <= cfg.hang_ticks;
				end
				MODE_HANG: begin
					hold_q <= hold_q - HANG_W'(1);
				end
				MODE_DECAY: begin
					env_q <= env_q - delta_s1;
				end
				default: begin
				end
			endcase
		end
	end

	a_env_max: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= EnvMax)
		else $error("envelope above full scale");

	a_attack_reload: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd && mode_s1 == MODE_ATTACK |=> hold_q == $past(cfg.hang_ticks))
		else $error("hang counter not reloaded on attack");

	a_decay_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd && mode_s1 == MODE_DECAY |=> env_q <= $past(env_q))
		else $error("envelope grew during decay");

endmodule

`default_nettype wire

// ===== hw/rtl/agc_divmul.sv =====
`default_nettype none

module agc_divmul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  agc_pkg::div_ctl_t                   ctl,
	input  logic        [agc_pkg::MAG_W-1:0]    mag,
	input  logic signed [agc_pkg::SAMPLE_W-1:0] sample,
	output logic signed [agc_pkg::ACC_W-1:0]    product,
	output logic                                done
);
	import agc_pkg::*;

	localparam int CntW = $clog2(QUOT_W + 1);
	localparam int IdxW = $clog2(QUOT_W);

	logic        [MAG_W-1:0] div_q;
	logic        [MAG_W-1:0] rem_q;
	logic        [CntW-1:0]  cnt_q;
	logic        [IdxW-1:0]  bit_idx;
	logic        [MAG_W:0]   trial;
	logic        [MAG_W:0]   diff;
	logic                    ge;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] addend;

	// restoring division, quotient MSB first; each quotient bit is folded
	// straight into a Horner-form multiply of the sample
	assign bit_idx = IdxW'(cnt_q - CntW'(1));
	assign trial   = {rem_q, SETPOINT[bit_idx]};
	assign diff    = trial - {1'b0, div_q};
	assign ge      = trial >= {1'b0, div_q};
	assign addend  = ge ? ACC_W'(sample) : '0;
	assign product = acc_q;
	assign done    = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= (mag == '0) ? '0 : CntW'(QUOT_W);
		end else if (ctl.step) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			div_q <= mag;
			rem_q <= '0;
			acc_q <= (mag == '0) ? ACC_W'(sample) : '0;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			acc_q <= (acc_q <<< 1) + addend;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QUOT_W))
		else $error("bit counter out of range");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

	a_no_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> !done)
		else $error("step issued after last quotient bit");

endmodule

`default_nettype wire

// ===== verif/audio_agc_hang_softclip_test.sv =====
module audio_agc_hang_softclip_test;
	import agc_pkg::*;

	localparam int     WATCHDOG_LIMIT = 3000;
	localparam int     DRAIN_CYCLES   = 25;
	localparam longint SP             = longint'(SETPOINT);
	localparam longint LIM            = longint'(LIMIT);
	localparam cfg_idx_t CFG_UNUSED   = 2'd3;

	typedef enum {SEG_SILENT, SEG_QUIET, SEG_TONE, SEG_LOUD, SEG_NEG, SEG_ANY} seg_kind_t;

	logic                       clk             = 1'b0;
	logic                       arst_n          = 1'b0;
	logic                       pcm_in_valid    = 1'b0;
	logic                       pcm_in_ready;
	logic signed [SAMPLE_W-1:0] pcm_in          = '0;
	logic                       audio_out_valid;
	logic                       audio_out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] audio_out;
	logic                       cfg_we          = 1'b0;
	cfg_idx_t                   cfg_index       = '0;
	logic [CFG_DATA_W-1:0]      cfg_data        = '0;

	// predictor state and register copy
	logic [ACC_W-1:0]   env_level;
	logic [HANG_W-1:0]  hang_left;
	logic [SHIFT_W-1:0] cfg_attack;
	logic [SHIFT_W-1:0] cfg_decay;
	logic [HANG_W-1:0]  cfg_hang;

	logic [SAMPLE_W-1:0] samples_to_send[$];
	logic [SAMPLE_W-1:0] out_samples_due[$];

	int   errors = 0;
	logic drain_hold = 1'b0;

	audio_agc_hang_softclip dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.pcm_in_valid    (pcm_in_valid),
		.pcm_in_ready    (pcm_in_ready),
		.pcm_in          (pcm_in),
		.audio_out_valid (audio_out_valid),
		.audio_out_ready (audio_out_ready),
		.audio_out       (audio_out),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [SAMPLE_W-1:0] gain_clip_sample(logic signed [SAMPLE_W-1:0] smp);
		longint s;
		longint scaled;
		longint env;
		longint mag;
		longint aud;
		s      = smp;
		scaled = s * 65536;
		env    = longint'(env_level);
		if (s > 0 && scaled > env) begin
			env       = env + ((scaled - env) >> cfg_attack);
			hang_left = cfg_hang;
		end else if (hang_left != 0) begin
			hang_left = hang_left - 1'b1;
		end else if (env > 0) begin
			env = env - (env >> cfg_decay);
		end
		env_level = env[ACC_W-1:0];
		mag = longint'(env_level) >> 16;
		aud = s;
		if (mag > 0)
			aud = s * (SP / mag);
		// soft knee, mirrored on the negative side
		if (aud > SP)
			aud = SP + ((aud - SP) >>> 1);
		else if (aud < -SP)
			aud = -(SP + ((-aud - SP) >>> 1));
		if (aud > LIM)
			aud = LIM;
		if (aud < -LIM)
			aud = -LIM;
		return aud[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(seg_kind_t kind);
		int v;
		bit neg;
		neg = 1'($urandom_range(0, 1));
		case (kind)
			SEG_SILENT: v = 0;
			SEG_QUIET:  v = $urandom_range(0, 300);
			SEG_TONE:   v = $urandom_range(0, 4000);
			SEG_LOUD:   v = $urandom_range(24000, 32767);
			SEG_NEG: begin
				v   = $urandom_range(1, 32768);
				neg = 1'b1;
			end
			default:    return SAMPLE_W'($urandom());
		endcase
		if (neg)
			v = -v;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
		logic [SAMPLE_W-1:0] want);
		$display("mismatch: %s got %0d want %0d", what, $signed(got), $signed(want));
		errors++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_ATTACK_SHIFT: cfg_attack = data[SHIFT_W-1:0];
			CFG_DECAY_SHIFT:  cfg_decay  = data[SHIFT_W-1:0];
			CFG_HANG_TICKS:   cfg_hang   = data;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (samples_to_send.size() != 0 || pcm_in_valid || out_samples_due.size() != 0)
			@(negedge clk);
	endtask

	// random runs of loud, quiet, silent, tone, negative and arbitrary samples so hang expires and decay sets the gain
	task automatic fill_phase(int count);
		int        done;
		int        len;
		seg_kind_t kind;
		done = 0;
		while (done < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2: kind = SEG_LOUD;
				3, 4:    kind = SEG_QUIET;
				5:       kind = SEG_SILENT;
				6, 7:    kind = SEG_TONE;
				8:       kind = SEG_NEG;
				default: kind = SEG_ANY;
			endcase
			len = $urandom_range(3, 25);
			repeat (len)
				samples_to_send.push_back(pick_sample(kind));
			done += len;
		end
	endtask

	// sender: bursts and gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : drive
		bit took;
		if (arst_n) begin
			took = pcm_in_valid && pcm_in_ready;
			if (took)
				out_samples_due.push_back(gain_clip_sample(pcm_in));
			if (pcm_in_valid && !took) begin
			end else if (gap_left != 0) begin
				gap_left--;
				pcm_in_valid <= 1'b0;
			end else if (samples_to_send.size() != 0 && !drain_hold) begin
				pcm_in       <= samples_to_send.pop_front();
				pcm_in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left--;
				end
			end else begin
				pcm_in_valid <= 1'b0;
			end
		end
	end

	// receiver: rotating ready pattern, reloaded now and then
	logic [7:0] ready_pat = 8'hFF;
	int         pat_left  = 0;

	always @(posedge clk) begin : stall
		if (pat_left == 0) begin
			case ($urandom_range(0, 3))
				0:       ready_pat = 8'hFF;
				1:       ready_pat = 8'h01;
				default: ready_pat = 8'($urandom_range(1, 255));
			endcase
			pat_left = $urandom_range(16, 96);
		end else begin
			pat_left--;
		end
		ready_pat = {ready_pat[6:0], ready_pat[7]};
		audio_out_ready <= ready_pat[0];
	end

	always @(posedge clk) begin : watch
		logic [SAMPLE_W-1:0] want;
		if (arst_n && audio_out_valid && audio_out_ready) begin
			if (out_samples_due.size() == 0) begin
				report_mismatch("unexpected beat", audio_out, '0);
			end else begin
				want = out_samples_due.pop_front();
				if (audio_out !== want)
					report_mismatch("audio_out", audio_out, want);
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin : dog
		if ((pcm_in_valid && pcm_in_ready) || (audio_out_valid && audio_out_ready))
			idle_cycles = 0;
		else if (samples_to_send.size() != 0 || pcm_in_valid || out_samples_due.size() != 0)
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	logic [SAMPLE_W-1:0] opening [0:11] = '{
		16'h8000, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF, 16'h0000,
		16'h0001, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h5555, 16'hAAAA
	};

	initial begin : stim
		int n;
		logic [SHIFT_W-1:0] sh;
		env_level  = '0;
		hang_left  = '0;
		cfg_attack = ATTACK_SHIFT_RST;
		cfg_decay  = DECAY_SHIFT_RST;
		cfg_hang   = HANG_TICKS_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, zero envelope first so negatives pass at unity gain
		foreach (opening[i])
			samples_to_send.push_back(opening[i]);
		wait_drained();

		// fastest attack, instant decay, no hang
		write_reg(CFG_ATTACK_SHIFT, 16'd0);
		write_reg(CFG_DECAY_SHIFT, 16'd0);
		write_reg(CFG_HANG_TICKS, 16'd0);
		@(negedge clk);
		samples_to_send.push_back(16'h7FFF);
		samples_to_send.push_back(16'h0064);
		samples_to_send.push_back(16'h0001);
		samples_to_send.push_back(16'h0002);
		samples_to_send.push_back(16'h8000);
		wait_drained();

		// shifts too large to move the envelope, longest hang
		write_reg(CFG_ATTACK_SHIFT, 16'hFFFF);
		write_reg(CFG_DECAY_SHIFT, 16'hFFFF);
		write_reg(CFG_HANG_TICKS, 16'hFFFF);
		write_reg(CFG_UNUSED, 16'h5A5A);
		@(negedge clk);
		samples_to_send.push_back(16'h0001);
		samples_to_send.push_back(16'h7FFF);
		samples_to_send.push_back(16'h0000);
		samples_to_send.push_back(16'h0000);
		samples_to_send.push_back(16'h8000);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			sh = SHIFT_W'(($urandom_range(0, 6) == 0) ?
				$urandom_range(9, 31) : $urandom_range(0, 8));
			if (ph == 0)
				sh = 0;
			write_reg(CFG_ATTACK_SHIFT, CFG_DATA_W'(($urandom() & 32'hFFE0) | sh));
			sh = SHIFT_W'(($urandom_range(0, 6) == 0) ?
				$urandom_range(11, 31) : $urandom_range(0, 10));
			if (ph == 7)
				sh = 31;
			write_reg(CFG_DECAY_SHIFT, CFG_DATA_W'(($urandom() & 32'hFFE0) | sh));
			write_reg(CFG_HANG_TICKS, CFG_DATA_W'(($urandom_range(0, 5) == 0) ?
				$urandom_range(0, 65535) : $urandom_range(0, 40)));
			if (ph == 3)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
			@(negedge clk);
			n = $urandom_range(40, 50);
			fill_phase(n);
			// hold the sender midway through the phase until the pipe has emptied
			while (samples_to_send.size() > n / 2)
				@(negedge clk);
			drain_hold = 1'b1;
			while (pcm_in_valid || out_samples_due.size() != 0)
				@(negedge clk);
			drain_hold = 1'b0;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
